// ===== rtl/yuv420_to_rgb_pair_converter_defines.svh =====
// Assertion macros shared by the converter RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef YUV420_TO_RGB_PAIR_CONVERTER_DEFINES_SVH
`define YUV420_TO_RGB_PAIR_CONVERTER_DEFINES_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset
`define YRP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("yrp: assertion failed");

// Condition must never be true at a clock edge outside reset
`define YRP_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("yrp: forbidden condition seen");

`else

`define YRP_ASSERT(label, prop)
`define YRP_NEVER(label, cond)

`endif

`endif

// ===== rtl/yrp_pkg.sv =====
package yrp_pkg;

    // Chroma term widths (two's complement)
    localparam int TERM_RG_W = 19;
    localparam int TERM_B_W  = 20;

    // Pixel sum widths before the scaling shift
    localparam int EVEN_SUM_W = 21;
    localparam int ODD_SUM_W  = 22;
    localparam int EVEN_SHIFT = 10;
    localparam int ODD_SHIFT  = 11;

    // Blended chroma 3*near + far, 0..1020
    localparam int CHROMA_W = 10;

    // Fixed-point BT.601 coefficients
    localparam int signed RED_V_MUL   = 409;
    localparam int signed GREEN_U_MUL = -100;
    localparam int signed GREEN_V_MUL = -208;
    localparam int signed BLUE_U_MUL  = 516;
    localparam int signed LUMA_EVEN_MUL = 298 * 4;
    localparam int signed LUMA_ODD_MUL  = 298 * 8;

    localparam int signed K_RED   = 128 * 4 - 16 * 298 * 4 - 409 * 512;
    localparam int signed K_GREEN = 128 * 4 - 16 * 298 * 4 + 100 * 512 + 208 * 512;
    localparam int signed K_BLUE  = 128 * 4 - 16 * 298 * 4 - 516 * 512;

    // Shifted sum, before clamping; same width for even and odd pixels
    localparam int SCALED_W = EVEN_SUM_W - EVEN_SHIFT;

    typedef logic signed [TERM_RG_W-1:0] term_rg_t;
    typedef logic signed [TERM_B_W-1:0]  term_b_t;

    // One queued pixel pair: own chroma terms, the previous pair's terms for the
    // odd pixel, and both luma samples
    typedef struct packed {
        term_rg_t    term_red;
        term_rg_t    term_green;
        term_b_t     term_blue;
        term_rg_t    prior_red;
        term_rg_t    prior_green;
        term_b_t     prior_blue;
        logic [7:0]  luma_even;
        logic [7:0]  luma_odd;
    } pair_entry_t;

    // Floor-shifted value clamped to 0..255
    function automatic logic [7:0] clamp8(input logic [SCALED_W-1:0] q);
        logic [7:0] res;
        if (q[SCALED_W-1])
        begin
            res = 8'd0;
        end
        else if (q[SCALED_W-2:8] != '0)
        begin
            res = 8'hFF;
        end
        else
        begin
            res = q[7:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/yrp_channels.sv =====
// Input channel: one pixel pair of 4:2:0 samples per transaction
interface yrp_yuv_if;
    logic       valid;
    logic       ready;
    logic       row_start;
    logic [7:0] luma_even;
    logic [7:0] luma_odd;
    logic [7:0] u_near;
    logic [7:0] u_far;
    logic [7:0] v_near;
    logic [7:0] v_far;

    modport source (
        output valid, row_start, luma_even, luma_odd, u_near, u_far, v_near, v_far,
        input  ready
    );
    modport sink (
        input  valid, row_start, luma_even, luma_odd, u_near, u_far, v_near, v_far,
        output ready
    );
endinterface

// Output channel: one RGB pixel pair per transaction
interface yrp_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_even;
    logic [7:0] green_even;
    logic [7:0] blue_even;
    logic [7:0] red_odd;
    logic [7:0] green_odd;
    logic [7:0] blue_odd;

    modport source (
        output valid, red_even, green_even, blue_even, red_odd, green_odd, blue_odd,
        input  ready
    );
    modport sink (
        input  valid, red_even, green_even, blue_even, red_odd, green_odd, blue_odd,
        output ready
    );
endinterface

// ===== rtl/yuv420_to_rgb_pair_converter.sv =====
// Channel | Dir | Transaction
// --------+-----+-------------------------------------------------------------
// yuv     | in  | row_start, luma even/odd, u and v of near and far chroma line
// rgb     | out | red, green, blue of even and odd pixel, clamped to 0..255
//
// One pixel pair per clock sustained while rgb.ready is high; the queue is
// written when it accepts the yuv transaction and the output register when
// the pair leaves the queue, and rgb shows the pair from that register.
// The queue holds QUEUE_DEPTH pairs; yuv.ready drops only when it is full.
// Reset clears the stored chroma terms of the previous pair, the queue and
// the output valid flag.
module yuv420_to_rgb_pair_converter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    yrp_yuv_if.sink    yuv,
    yrp_rgb_if.source  rgb
);

    logic                 push_valid;
    logic                 push_ready;
    yrp_pkg::pair_entry_t push_entry;
    logic                 pop_valid;
    logic                 pop_ready;
    yrp_pkg::pair_entry_t pop_entry;

    yrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .yuv        (yuv),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    yrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    yrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .rgb       (rgb)
    );

endmodule

// ===== rtl/yrp_queue.sv =====
`include "yuv420_to_rgb_pair_converter_defines.svh"

module yrp_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  yrp_pkg::pair_entry_t push_entry,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output yrp_pkg::pair_entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    yrp_pkg::pair_entry_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    // Handshake on both sides
    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = entries_reg[rd_ptr_reg];

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `YRP_ASSERT(q_count_bound, count_reg <= CNT_W'(DEPTH))
    `YRP_ASSERT(q_count_up, push && !pop |=> count_reg == $past(count_reg) + 1'b1)
    `YRP_NEVER(q_empty_ptrs, count_reg == '0 && wr_ptr_reg != rd_ptr_reg)

endmodule

// ===== rtl/yrp_front.sv =====
module yrp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    yrp_yuv_if.sink              yuv,
    output logic                 push_valid,
    input  logic                 push_ready,
    output yrp_pkg::pair_entry_t push_entry
);

    logic [yrp_pkg::CHROMA_W-1:0] cu;
    logic [yrp_pkg::CHROMA_W-1:0] cv;
    yrp_pkg::term_rg_t            term_red;
    yrp_pkg::term_rg_t            term_green;
    yrp_pkg::term_b_t             term_blue;
    yrp_pkg::term_rg_t            prev_red_reg;
    yrp_pkg::term_rg_t            prev_green_reg;
    yrp_pkg::term_b_t             prev_blue_reg;
    logic                         accept;

    // Pass the transaction straight into the queue
    assign push_valid = yuv.valid;
    assign yuv.ready  = push_ready;
    assign accept     = yuv.valid && push_ready;

    // Blend chroma 3:1 toward this row's line
    assign cu = yrp_pkg::CHROMA_W'(yuv.u_near) + {1'b0, yuv.u_near, 1'b0}
              + yrp_pkg::CHROMA_W'(yuv.u_far);
    assign cv = yrp_pkg::CHROMA_W'(yuv.v_near) + {1'b0, yuv.v_near, 1'b0}
              + yrp_pkg::CHROMA_W'(yuv.v_far);

    // Form chroma terms
    assign term_red = yrp_pkg::TERM_RG_W'(yrp_pkg::RED_V_MUL * int'(cv) + yrp_pkg::K_RED);
    assign term_green = yrp_pkg::TERM_RG_W'(yrp_pkg::GREEN_U_MUL * int'(cu)
                      + yrp_pkg::GREEN_V_MUL * int'(cv) + yrp_pkg::K_GREEN);
    assign term_blue = yrp_pkg::TERM_B_W'(yrp_pkg::BLUE_U_MUL * int'(cu) + yrp_pkg::K_BLUE);

    // Pick the odd pixel's neighbor terms: own terms at a row start
    always_comb
    begin
        push_entry.term_red    = term_red;
        push_entry.term_green  = term_green;
        push_entry.term_blue   = term_blue;
        push_entry.luma_even   = yuv.luma_even;
        push_entry.luma_odd    = yuv.luma_odd;
        if (yuv.row_start)
        begin
            push_entry.prior_red   = term_red;
            push_entry.prior_green = term_green;
            push_entry.prior_blue  = term_blue;
        end
        else
        begin
            push_entry.prior_red   = prev_red_reg;
            push_entry.prior_green = prev_green_reg;
            push_entry.prior_blue  = prev_blue_reg;
        end
    end

    // Hold terms of the last accepted pair for the next one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_red_reg   <= '0;
            prev_green_reg <= '0;
            prev_blue_reg  <= '0;
        end
        else if (accept)
        begin
            prev_red_reg   <= term_red;
            prev_green_reg <= term_green;
            prev_blue_reg  <= term_blue;
        end
    end

endmodule

// ===== rtl/yrp_back.sv =====
module yrp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  yrp_pkg::pair_entry_t pop_entry,
    yrp_rgb_if.source            rgb
);

    logic signed [yrp_pkg::EVEN_SUM_W-1:0] even_red, even_green, even_blue;
    logic signed [yrp_pkg::ODD_SUM_W-1:0]  odd_red, odd_green, odd_blue;
    logic                                  load;
    logic                                  out_valid_reg, out_valid_next;
    logic [7:0] red_even_reg, green_even_reg, blue_even_reg;
    logic [7:0] red_odd_reg, green_odd_reg, blue_odd_reg;

    // Take a queued pair whenever the output register is free or draining
    assign load      = pop_valid && (!out_valid_reg || rgb.ready);
    assign pop_ready = !out_valid_reg || rgb.ready;

    // Add luma to chroma terms
    assign even_red = yrp_pkg::EVEN_SUM_W'(int'(pop_entry.term_red)
                    + yrp_pkg::LUMA_EVEN_MUL * int'(pop_entry.luma_even));
    assign even_green = yrp_pkg::EVEN_SUM_W'(int'(pop_entry.term_green)
                      + yrp_pkg::LUMA_EVEN_MUL * int'(pop_entry.luma_even));
    assign even_blue = yrp_pkg::EVEN_SUM_W'(int'(pop_entry.term_blue)
                     + yrp_pkg::LUMA_EVEN_MUL * int'(pop_entry.luma_even));
    assign odd_red = yrp_pkg::ODD_SUM_W'(int'(pop_entry.term_red)
                   + int'(pop_entry.prior_red)
                   + yrp_pkg::LUMA_ODD_MUL * int'(pop_entry.luma_odd));
    assign odd_green = yrp_pkg::ODD_SUM_W'(int'(pop_entry.term_green)
                     + int'(pop_entry.prior_green)
                     + yrp_pkg::LUMA_ODD_MUL * int'(pop_entry.luma_odd));
    assign odd_blue = yrp_pkg::ODD_SUM_W'(int'(pop_entry.term_blue)
                    + int'(pop_entry.prior_blue)
                    + yrp_pkg::LUMA_ODD_MUL * int'(pop_entry.luma_odd));

    // Keep the result until the sink takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rgb.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Scale, clamp and register the pixel pair
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_even_reg   <= yrp_pkg::clamp8(
                even_red[yrp_pkg::EVEN_SUM_W-1:yrp_pkg::EVEN_SHIFT]);
            green_even_reg <= yrp_pkg::clamp8(
                even_green[yrp_pkg::EVEN_SUM_W-1:yrp_pkg::EVEN_SHIFT]);
            blue_even_reg  <= yrp_pkg::clamp8(
                even_blue[yrp_pkg::EVEN_SUM_W-1:yrp_pkg::EVEN_SHIFT]);
            red_odd_reg    <= yrp_pkg::clamp8(
                odd_red[yrp_pkg::ODD_SUM_W-1:yrp_pkg::ODD_SHIFT]);
            green_odd_reg  <= yrp_pkg::clamp8(
                odd_green[yrp_pkg::ODD_SUM_W-1:yrp_pkg::ODD_SHIFT]);
            blue_odd_reg   <= yrp_pkg::clamp8(
                odd_blue[yrp_pkg::ODD_SUM_W-1:yrp_pkg::ODD_SHIFT]);
        end
    end

    assign rgb.valid      = out_valid_reg;
    assign rgb.red_even   = red_even_reg;
    assign rgb.green_even = green_even_reg;
    assign rgb.blue_even  = blue_even_reg;
    assign rgb.red_odd    = red_odd_reg;
    assign rgb.green_odd  = green_odd_reg;
    assign rgb.blue_odd   = blue_odd_reg;

endmodule
